// ----- rtl/dns_name_text_to_wire_unit_defines.svh -----
// ----------------------------------------------------------------------------
// DNS name text to wire unit, assertion macros
// Shared helpers for the concurrent checks in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_TEXT_TO_WIRE_UNIT_DEFINES_SVH
`define DNS_NAME_TEXT_TO_WIRE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DNTW_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DNTW_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/dntw_pkg.sv -----
// ----------------------------------------------------------------------------
// DNS name text to wire package
// Types and constants shared by the converter core, result buffer and top.
// ----------------------------------------------------------------------------
`default_nettype none

package dntw_pkg;

	typedef enum logic [1:0] {
		ST_DATA    = 2'd0,
		ST_VALID   = 2'd1,
		ST_PARTIAL = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef struct packed {
		logic          last;
		status_t       status;
		logic [7:0]    value;
		logic [7:0]    offset;
	} res_t;

	localparam int unsigned BATCH_MAX = 4;

	typedef struct packed {
		logic [2:0]                cnt;
		res_t [BATCH_MAX-1:0]      item;
	} batch_t;

	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_BSLASH    = 8'h5C;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'd32;
	localparam logic [7:0] TERM_PARTIAL = 8'hFF;
	localparam logic [7:0] TERM_FQDN    = 8'h00;
	localparam logic [9:0] DEC_MAX      = 10'd255;

endpackage

`default_nettype wire

// ----- rtl/dntw_core.sv -----
// ----------------------------------------------------------------------------
// DNS name text to wire converter core
// Holds the running name state and turns one character into a batch of
// up to four buffer writes in a single combinational pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dns_name_text_to_wire_unit_defines.svh"

module dntw_core
	import dntw_pkg::*;
#(
	parameter int MAX_LABEL_BYTES = 63,
	parameter int MAX_NAME_BYTES  = 255
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       proc,
	input  wire logic [7:0] char_i,
	input  wire logic       fin_i,
	output batch_t          batch
);

	typedef enum logic [1:0] {
		ESC_NONE  = 2'd0,
		ESC_SLASH = 2'd1,
		ESC_ONE   = 2'd2,
		ESC_TWO   = 2'd3
	} esc_t;

	logic [8:0] tl_q;
	logic [6:0] ll_q;
	esc_t       ep_q;
	logic [9:0] ev_q;
	logic       err_q;
	logic       ewd_q;

	logic [8:0] ntl;
	logic [6:0] nll;
	esc_t       nep;
	logic [9:0] nev;
	logic       nerr;
	logic       newd;
	logic       clear;

	always_comb begin
		logic [2:0] k;
		logic       add;
		logic       dot;
		logic       digit;
		logic       do_el;
		logic [7:0] b;
		logic [9:0] dv;
		logic [9:0] v;
		logic [6:0] nl;
		ntl   = tl_q;
		nll   = ll_q;
		nep   = ep_q;
		nev   = ev_q;
		nerr  = err_q;
		newd  = ewd_q;
		clear = 1'b0;
		batch = '0;
		k     = '0;
		add   = 1'b0;
		dot   = 1'b0;
		do_el = 1'b0;
		b     = char_i;
		digit = char_i inside {[CH_ZERO:CH_NINE]};
		dv    = 10'(char_i - CH_ZERO);
		v     = (ev_q << 3) + (ev_q << 1) + dv;
		nl    = ll_q + 7'd1;
		if (fin_i && !err_q && tl_q == 9'd1 && ll_q == 7'd0 && ep_q == ESC_NONE &&
				char_i == CH_DOT) begin
			batch.item[0] = '{last: 1'b0, status: ST_DATA, value: 8'd0, offset: 8'd1};
			batch.item[1] = '{last: 1'b1, status: ST_VALID, value: 8'd1, offset: 8'd0};
			k     = 3'd2;
			clear = 1'b1;
		end else begin
			if (!err_q) begin
				case (ep_q)
					ESC_NONE: begin
						if (char_i == CH_BSLASH) begin
							nep = ESC_SLASH;
						end else if (char_i == CH_DOT) begin
							dot = 1'b1;
						end else begin
							add = 1'b1;
						end
					end
					ESC_SLASH: begin
						if (digit) begin
							nev = dv;
							nep = ESC_ONE;
						end else begin
							nep = ESC_NONE;
							add = 1'b1;
						end
					end
					ESC_ONE: begin
						if (digit) begin
							nev = v;
							nep = ESC_TWO;
						end else begin
							nerr = 1'b1;
						end
					end
					default: begin
						if (digit) begin
							nep = ESC_NONE;
							nev = '0;
							if (v > DEC_MAX) begin
								nerr = 1'b1;
							end else begin
								add = 1'b1;
								b   = v[7:0];
							end
						end else begin
							nerr = 1'b1;
						end
					end
				endcase
				if (add) begin
					if (b inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
						b = b + CASE_OFFSET;
					end
					if (nl > 7'(MAX_LABEL_BYTES) ||
							10'(tl_q) + 10'(nl) + 10'd1 > 10'(MAX_NAME_BYTES)) begin
						nerr = 1'b1;
					end else begin
						nll = nl;
						batch.item[k[1:0]] = '{last: 1'b0, status: ST_DATA, value: b,
							offset: 8'(tl_q + 9'(nl))};
						k = k + 3'd1;
					end
				end
				newd = dot;
			end
			if (fin_i && !nerr && nep != ESC_NONE) begin
				nerr = 1'b1;
			end
			do_el = !nerr && (fin_i || dot);
			if (do_el) begin
				if (nll == 7'd0 || 10'(ntl) + 10'(nll) + 10'd1 > 10'(MAX_NAME_BYTES)) begin
					nerr = 1'b1;
				end else begin
					batch.item[k[1:0]] = '{last: 1'b0, status: ST_DATA, value: 8'(nll),
						offset: ntl[7:0]};
					k   = k + 3'd1;
					ntl = ntl + 9'(nll) + 9'd1;
					nll = '0;
				end
			end
			if (!fin_i) begin
				if (nerr) begin
					k = '0;
				end
			end else begin
				clear = 1'b1;
				if (nerr) begin
					batch.item[0] = '{last: 1'b1, status: ST_INVALID, value: 8'd0,
						offset: 8'd0};
					k = 3'd1;
				end else begin
					batch.item[k[1:0]] = '{last: 1'b0, status: ST_DATA,
						value: newd ? TERM_FQDN : TERM_PARTIAL, offset: ntl[7:0]};
					k = k + 3'd1;
					batch.item[k[1:0]] = '{last: 1'b1,
						status: newd ? ST_VALID : ST_PARTIAL, value: ntl[7:0],
						offset: 8'd0};
					k = k + 3'd1;
				end
			end
		end
		batch.cnt = k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q  <= 9'd1;
			ll_q  <= '0;
			ep_q  <= ESC_NONE;
			ev_q  <= '0;
			err_q <= 1'b0;
			ewd_q <= 1'b0;
		end else if (proc) begin
			if (clear) begin
				tl_q  <= 9'd1;
				ll_q  <= '0;
				ep_q  <= ESC_NONE;
				ev_q  <= '0;
				err_q <= 1'b0;
				ewd_q <= 1'b0;
			end else begin
				tl_q  <= ntl;
				ll_q  <= nll;
				ep_q  <= nep;
				ev_q  <= nev;
				err_q <= nerr;
				ewd_q <= newd;
			end
		end
	end

	`DNTW_ASSERT_NXT(a_fin_resets, clk, arst_n, proc && fin_i, tl_q == 9'd1 && ll_q == 7'd0 && ep_q == ESC_NONE && !err_q && !ewd_q, "State not cleared after the last character.")
	`DNTW_ASSERT_IMP(a_label_bound, clk, arst_n, 1'b1, ll_q <= 7'(MAX_LABEL_BYTES), "Label length exceeds its limit.")
	`DNTW_ASSERT_IMP(a_name_bound, clk, arst_n, 1'b1, 10'(tl_q) + 10'(ll_q) <= 10'(MAX_NAME_BYTES), "Name length exceeds its limit.")

endmodule

`default_nettype wire

// ----- rtl/dntw_outbuf.sv -----
// ----------------------------------------------------------------------------
// DNS name text to wire result buffer
// Holds one batch of up to four results and hands them out one per
// transaction; a new batch loads as the previous one drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dns_name_text_to_wire_unit_defines.svh"

module dntw_outbuf
	import dntw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load_i,
	input  batch_t           batch_i,
	output logic             can_load,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);

	res_t [BATCH_MAX-1:0] arr_q;
	logic [2:0]           rem_q;
	logic [1:0]           head_q;
	res_t                 cur;
	logic                 pop;

	assign cur      = arr_q[head_q];
	assign m_tvalid = rem_q != 3'd0;
	assign pop      = m_tvalid && m_tready;
	assign can_load = rem_q == 3'd0 || (rem_q == 3'd1 && m_tready);
	assign m_tdata  = {cur.value, cur.offset};
	assign m_tuser  = cur.status;
	assign m_tlast  = cur.last;

	always_ff @(posedge clk) begin
		if (load_i) begin
			arr_q <= batch_i.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			head_q <= '0;
		end else if (load_i) begin
			rem_q  <= batch_i.cnt;
			head_q <= '0;
		end else if (pop) begin
			rem_q  <= rem_q - 3'd1;
			head_q <= head_q + 2'd1;
		end
	end

	`DNTW_ASSERT_IMP(a_rem_range, clk, arst_n, 1'b1, rem_q <= 3'd4, "Result count out of range.")
	`DNTW_ASSERT_IMP(a_last_is_final, clk, arst_n, m_tvalid && m_tlast, rem_q == 3'd1, "Status result is not the final entry of its batch.")
	`DNTW_ASSERT_NXT(a_empty_load, clk, arst_n, load_i && batch_i.cnt == 3'd0, rem_q == 3'd0, "Empty batch produced output.")

endmodule

`default_nettype wire

// ----- rtl/dns_name_text_to_wire_unit.sv -----
// ----------------------------------------------------------------------------
// DNS name text to wire unit
// Converts a presentation-form DNS name, one character per transaction, into
// offset and byte writes of the length-prefixed wire form.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  tdata: text_char; tlast: final_char
// m_*      out        m_tvalid/m_tready  tdata: wire_offset, wire_value;
//                                        tuser: name_status; tlast: run_end
//
// One character is taken per cycle; the result buffer registers its writes.
// A character yields at most one write, except the last one of a name, which
// yields up to four; those drain one per cycle from the result buffer.
// Sustained rate is one character per cycle while each yields one write.
// Reset returns the name state to an empty name and empties both registers.
// A stall on the output holds the buffer and, once it is full, the input.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_name_text_to_wire_unit
	import dntw_pkg::*;
#(
	parameter int MAX_LABEL_BYTES = 63,
	parameter int MAX_NAME_BYTES  = 255
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] text_char
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] wire_offset, [15:8] wire_value
	output logic [1:0]       m_tuser,   // [1:0] name_status
	output logic             m_tlast
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       fin_s1;
	logic       can_load;
	logic       proc;
	batch_t     batch;

	assign proc     = valid_s1 && can_load;
	assign s_tready = !valid_s1 || can_load;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			fin_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	dntw_core #(
		.MAX_LABEL_BYTES (MAX_LABEL_BYTES),
		.MAX_NAME_BYTES  (MAX_NAME_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.proc   (proc),
		.char_i (char_s1),
		.fin_i  (fin_s1),
		.batch  (batch)
	);

	dntw_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_i   (proc),
		.batch_i  (batch),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
